/* rtl/core/dvrt_pkg.sv */
// shared constants and codes of the distance vector route table
package dvrt_pkg;

   // fixed widths of the transaction fields
   localparam int FUNC_W  = 2;
   localparam int PORT_AW = 32;
   localparam int COST_W  = 16;
   localparam int KIND_W  = 3;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_ADV    = 2'd3;

   // response kind codes
   localparam logic [KIND_W-1:0] KIND_NEXT_HOP = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NO_ROUTE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VEC      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_VEC_NONE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NO_CHG   = 3'd4;

   // cost that marks an unreachable destination
   localparam logic [COST_W-1:0] UNREACH = 16'hFFFF;

   // most vector entries sent in one answer
   localparam int MAX_RESULTS = 32;

endpackage

/* rtl/core/dvrt_req_if.sv */
// request channel of the route table
interface dvrt_req_if import dvrt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [PORT_AW-1:0]  neighbor_addr;
   logic [PORT_AW-1:0]  dest_addr;
   logic [COST_W-1:0]   cost;
   logic                first;
   logic                last;
   logic                entry_present;

   modport source (output valid, func, neighbor_addr, dest_addr, cost, first, last,
                   entry_present, input ready);
   modport sink   (input valid, func, neighbor_addr, dest_addr, cost, first, last,
                   entry_present, output ready);
endinterface

/* rtl/core/dvrt_rsp_if.sv */
// response channel of the route table
interface dvrt_rsp_if import dvrt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [PORT_AW-1:0]  addr;
   logic [COST_W-1:0]   cost_out;
   logic                last_out;
   logic                table_full;

   modport source (output valid, kind, addr, cost_out, last_out, table_full, input ready);
   modport sink   (input valid, kind, addr, cost_out, last_out, table_full, output ready);
endinterface

/* rtl/core/distance_vector_route_table_top.sv */
// Distance vector route table: one request transaction at a time, state held in
// three single-port-read memories (column addresses, host costs, cost matrix) with
// registered read data. Most memory walks read an element, then check or write it
// back. A lookup searches the columns, then scans the rows; an add searches rows and
// columns, fills the neighbor row and sends the vector; an advertisement entry
// searches rows and columns; a last advertisement item relaxes the host row and
// sends the vector; remove moves the rows, then the columns, then sends the vector.
// Responses leave through an output register and stall on rsp ready.
// The request channel is ready only while the sequencer is idle.
module distance_vector_route_table_top import dvrt_pkg::*; #(
   parameter int DESTINATIONS = 32,
   parameter int NEIGHBORS    = 8,
   parameter int ADDR_BITS    = 32
) (
   input  logic               clock,
   input  logic               reset,
   dvrt_req_if.sink           req_chan,
   dvrt_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [PORT_AW-1:0] csr_wr_data
);

   localparam int AW  = ADDR_BITS;
   localparam int CW  = $clog2(DESTINATIONS);
   localparam int DCW = $clog2(DESTINATIONS + 1);
   localparam int RW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int NCW = $clog2(NEIGHBORS + 1);
   localparam int CMD = 2 ** (RW + CW);

   typedef enum logic [25:0] {
      S_IDLE        = 26'h0000001,
      S_FROW_RD     = 26'h0000002,
      S_FROW_CHK    = 26'h0000004,
      S_FCOL_RD     = 26'h0000008,
      S_FCOL_CHK    = 26'h0000010,
      S_NCOL        = 26'h0000020,
      S_ATT_NEW     = 26'h0000040,
      S_ATT_FILL    = 26'h0000080,
      S_ADV_ENTRY   = 26'h0000100,
      S_ADV_WR      = 26'h0000200,
      S_ADV_LAST    = 26'h0000400,
      S_RLX_RD      = 26'h0000800,
      S_RLX_CHK     = 26'h0001000,
      S_RM_START    = 26'h0002000,
      S_RM_ROW_RD   = 26'h0004000,
      S_RM_ROW_WR   = 26'h0008000,
      S_RM_COL_RD   = 26'h0010000,
      S_RM_COL_WR   = 26'h0020000,
      S_EM_START    = 26'h0040000,
      S_EM_RD       = 26'h0080000,
      S_EM_OUT      = 26'h0100000,
      S_LK_RD       = 26'h0200000,
      S_LK_CHK      = 26'h0400000,
      S_LK_ADDR_RD  = 26'h0800000,
      S_LK_ADDR_OUT = 26'h1000000,
      S_OUT1        = 26'h2000000
   } state_type;

   // memories
   logic [AW-1:0]     dmem [DESTINATIONS];
   logic [COST_W-1:0] hmem [DESTINATIONS];
   logic [COST_W-1:0] cmem [CMD];

   logic              dm_we, hm_we, cm_we;
   logic [CW-1:0]     dm_waddr, hm_waddr, dm_raddr, hm_raddr;
   logic [RW+CW-1:0]  cm_waddr, cm_raddr;
   logic [AW-1:0]     dm_wdata;
   logic [COST_W-1:0] hm_wdata, cm_wdata;
   logic [AW-1:0]     dm_rdata_ff;
   logic [COST_W-1:0] hm_rdata_ff, cm_rdata_ff;

   // control and working registers
   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [AW-1:0]     key_ff, key_in;
   logic [AW-1:0]     dst_ff, dst_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              last_ff, last_in;
   logic              present_ff, present_in;
   logic              att_ff, att_in;
   logic [AW-1:0]     host_ff, host_in;
   logic [DCW-1:0]    dcount_ff, dcount_in;
   logic [NCW-1:0]    ncount_ff, ncount_in;
   logic [CW-1:0]     ncol_ff [NEIGHBORS];
   logic [CW-1:0]     ncol_in [NEIGHBORS];
   logic [CW-1:0]     ncol_shift [NEIGHBORS];
   logic [RW-1:0]     ncol_raddr;
   logic [CW-1:0]     ncol_rd;
   logic [RW-1:0]     cur_ff, cur_in;
   logic              improved_ff, improved_in;
   logic              open_ff, open_in;
   logic              dropped_ff, dropped_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [RW-1:0]     br_ff, br_in;
   logic              brv_ff, brv_in;
   logic [NCW-1:0]    i_ff, i_in, ip1;
   logic [DCW-1:0]    j_ff, j_in, jp1;
   logic              full_ff, full_in;
   logic [KIND_W-1:0] okind_ff, okind_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [PORT_AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               out_free;

   // subroutine events
   logic              col_hit, col_miss, row_hit, row_miss, att_fail;
   logic [CW-1:0]     hit_col;
   logic [RW-1:0]     hit_row;
   logic              open_eff;
   logic [7:0]        em_last_col;
   logic [COST_W:0]   relax_sum;

   assign ip1      = i_ff + NCW'(1);
   assign jp1      = j_ff + DCW'(1);
   assign ncol_rd  = ncol_ff[ncol_raddr];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign open_eff = open_ff && (NCW'(cur_ff) < ncount_ff);
   assign relax_sum = {1'b0, cm_rdata_ff} + (COST_W+1)'(1);
   assign em_last_col = ((8'(dcount_ff) - 8'd1) > 8'(MAX_RESULTS)) ? 8'(MAX_RESULTS)
                                                                     : 8'(dcount_ff) - 8'd1;

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.addr       = rsp_addr_ff;
   assign rsp_chan.cost_out   = rsp_cost_ff;
   assign rsp_chan.last_out   = rsp_last_ff;
   assign rsp_chan.table_full = rsp_full_ff;

   // neighbor columns after removing row_ff and its column
   always_comb begin
      for (int n = 0; n < NEIGHBORS; n++) begin
         ncol_shift[n] = ncol_ff[n];
      end
      for (int n = 0; n < NEIGHBORS - 1; n++) begin
         if (RW'(n) >= row_ff) begin
            ncol_shift[n] = ncol_ff[n + 1];
         end
      end
      for (int n = 0; n < NEIGHBORS; n++) begin
         if (ncol_shift[n] > col_ff) begin
            ncol_shift[n] = ncol_shift[n] - CW'(1);
         end
      end
   end

   // memory read addresses
   always_comb begin
      dm_raddr   = j_ff[CW-1:0];
      hm_raddr   = j_ff[CW-1:0];
      cm_raddr   = {i_ff[RW-1:0], col_ff};
      ncol_raddr = row_ff;
      unique case (state_ff)
         S_FROW_RD, S_FROW_CHK: begin
            ncol_raddr = i_ff[RW-1:0];
            dm_raddr   = ncol_rd;
         end
         S_RLX_RD:     cm_raddr = {cur_ff, j_ff[CW-1:0]};
         S_RM_ROW_RD:  cm_raddr = {ip1[RW-1:0], j_ff[CW-1:0]};
         S_RM_COL_RD: begin
            dm_raddr = jp1[CW-1:0];
            hm_raddr = jp1[CW-1:0];
            cm_raddr = {i_ff[RW-1:0], jp1[CW-1:0]};
         end
         // next hop address is held while the response waits
         S_LK_ADDR_RD, S_LK_ADDR_OUT: begin
            ncol_raddr = br_ff;
            dm_raddr   = ncol_rd;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      dst_in       = dst_ff;
      cost_in      = cost_ff;
      last_in      = last_ff;
      present_in   = present_ff;
      att_in       = att_ff;
      host_in      = host_ff;
      dcount_in    = dcount_ff;
      ncount_in    = ncount_ff;
      ncol_in      = ncol_ff;
      cur_in       = cur_ff;
      improved_in  = improved_ff;
      open_in      = open_ff;
      dropped_in   = dropped_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      best_in      = best_ff;
      br_in        = br_ff;
      brv_in       = brv_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      full_in      = full_ff;
      okind_in     = okind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_full_in  = rsp_full_ff;
      dm_we = 1'b0;  dm_waddr = j_ff[CW-1:0];  dm_wdata = dm_rdata_ff;
      hm_we = 1'b0;  hm_waddr = j_ff[CW-1:0];  hm_wdata = hm_rdata_ff;
      cm_we = 1'b0;  cm_waddr = {i_ff[RW-1:0], j_ff[CW-1:0]};  cm_wdata = cm_rdata_ff;
      col_hit = 1'b0;  col_miss = 1'b0;  row_hit = 1'b0;  row_miss = 1'b0;
      att_fail = 1'b0;
      hit_col = '0;
      hit_row = i_ff[RW-1:0];

      if (csr_wr_en) begin
         host_in = AW'(csr_wr_data);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in    = req_chan.func;
               dst_in     = AW'(req_chan.dest_addr);
               cost_in    = req_chan.cost;
               last_in    = req_chan.last;
               present_in = req_chan.entry_present;
               key_in     = AW'(req_chan.neighbor_addr);
               att_in     = 1'b0;
               i_in       = '0;
               full_in    = 1'b0;
               unique case (req_chan.func)
                  FUNC_LOOKUP: begin
                     key_in   = AW'(req_chan.dest_addr);
                     j_in     = DCW'(1);
                     state_in = S_FCOL_RD;
                  end
                  FUNC_ADD: begin
                     if (AW'(req_chan.neighbor_addr) == host_ff) begin
                        okind_in = KIND_NO_CHG;
                        state_in = S_OUT1;
                     end else begin
                        att_in   = 1'b1;
                        state_in = S_FROW_RD;
                     end
                  end
                  FUNC_REMOVE: state_in = S_FROW_RD;
                  default: begin
                     state_in = S_ADV_ENTRY;
                     if (req_chan.first) begin
                        open_in     = 1'b0;
                        dropped_in  = 1'b0;
                        improved_in = 1'b0;
                        if (AW'(req_chan.neighbor_addr) != host_ff) begin
                           att_in   = 1'b1;
                           state_in = S_FROW_RD;
                        end
                     end
                  end
               endcase
            end
         end

         // row search by neighbor address
         S_FROW_RD: begin
            if (i_ff >= ncount_ff) row_miss = 1'b1;
            else state_in = S_FROW_CHK;
         end
         S_FROW_CHK: begin
            if (dm_rdata_ff == key_ff) begin
               row_hit = 1'b1;
            end else begin
               i_in     = ip1;
               state_in = S_FROW_RD;
            end
         end

         // column search by address
         S_FCOL_RD: begin
            if (key_ff == host_ff) col_hit = 1'b1;
            else if (j_ff >= dcount_ff) col_miss = 1'b1;
            else state_in = S_FCOL_CHK;
         end
         S_FCOL_CHK: begin
            if (dm_rdata_ff == key_ff) begin
               col_hit = 1'b1;
               hit_col = j_ff[CW-1:0];
            end else begin
               j_in     = jp1;
               state_in = S_FCOL_RD;
            end
         end

         // new column: unreachable in every live row
         S_NCOL: begin
            if (i_ff >= ncount_ff) begin
               state_in = att_ff ? S_ATT_NEW : S_ADV_WR;
            end else begin
               cm_we    = 1'b1;
               cm_waddr = {i_ff[RW-1:0], col_ff};
               cm_wdata = UNREACH;
               i_in     = ip1;
            end
         end

         S_ATT_NEW: begin
            row_in = ncount_ff[RW-1:0];
            ncol_in[ncount_ff[RW-1:0]] = col_ff;
            ncount_in = ncount_ff + NCW'(1);
            j_in      = '0;
            state_in  = S_ATT_FILL;
         end

         // fresh neighbor row
         S_ATT_FILL: begin
            cm_we    = 1'b1;
            cm_waddr = {row_ff, j_ff[CW-1:0]};
            if (j_ff == '0) cm_wdata = COST_W'(1);
            else if (j_ff[CW-1:0] == col_ff) cm_wdata = '0;
            else cm_wdata = UNREACH;
            if (j_ff == '0) begin
               hm_we    = 1'b1;
               hm_waddr = col_ff;
               hm_wdata = COST_W'(1);
            end
            j_in = jp1;
            if (j_ff == DCW'(DESTINATIONS - 1)) begin
               if (func_ff == FUNC_ADD) begin
                  state_in = S_EM_START;
               end else begin
                  cur_in   = row_ff;
                  open_in  = 1'b1;
                  att_in   = 1'b0;
                  state_in = S_ADV_ENTRY;
               end
            end
         end

         S_ADV_ENTRY: begin
            open_in = open_eff;
            if (open_eff && present_ff) begin
               key_in   = dst_ff;
               att_in   = 1'b0;
               j_in     = DCW'(1);
               state_in = S_FCOL_RD;
            end else begin
               state_in = S_ADV_LAST;
            end
         end

         S_ADV_WR: begin
            cm_we    = 1'b1;
            cm_waddr = {cur_ff, col_ff};
            cm_wdata = cost_ff;
            state_in = S_ADV_LAST;
         end

         S_ADV_LAST: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else begin
               full_in    = dropped_ff;
               dropped_in = 1'b0;
               open_in    = 1'b0;
               if (open_ff) begin
                  j_in     = DCW'(1);
                  state_in = S_RLX_RD;
               end else begin
                  okind_in = KIND_NO_CHG;
                  state_in = S_OUT1;
               end
            end
         end

         // host row relaxation over the advertising row
         S_RLX_RD: begin
            if (j_ff >= dcount_ff) begin
               if (improved_ff) begin
                  state_in = S_EM_START;
               end else begin
                  okind_in = KIND_NO_CHG;
                  state_in = S_OUT1;
               end
            end else begin
               state_in = S_RLX_CHK;
            end
         end
         S_RLX_CHK: begin
            if (cm_rdata_ff != UNREACH && relax_sum < {1'b0, hm_rdata_ff}) begin
               hm_we       = 1'b1;
               hm_wdata    = relax_sum[COST_W-1:0];
               improved_in = 1'b1;
            end
            j_in     = jp1;
            state_in = S_RLX_RD;
         end

         // remove: squeeze the row list, then the column list
         S_RM_START: begin
            col_in    = ncol_rd;
            ncount_in = ncount_ff - NCW'(1);
            i_in      = NCW'(row_ff);
            j_in      = '0;
            state_in  = S_RM_ROW_RD;
         end
         S_RM_ROW_RD: begin
            if (i_ff >= ncount_ff) begin
               ncol_in  = ncol_shift;
               i_in     = '0;
               j_in     = DCW'(col_ff);
               state_in = S_RM_COL_RD;
            end else begin
               state_in = S_RM_ROW_WR;
            end
         end
         S_RM_ROW_WR: begin
            cm_we = 1'b1;
            if (j_ff == DCW'(DESTINATIONS - 1)) begin
               j_in = '0;
               i_in = ip1;
            end else begin
               j_in = jp1;
            end
            state_in = S_RM_ROW_RD;
         end
         S_RM_COL_RD: begin
            if (jp1 >= dcount_ff) begin
               dcount_in = dcount_ff - DCW'(1);
               state_in  = S_EM_START;
            end else begin
               state_in = S_RM_COL_WR;
            end
         end
         S_RM_COL_WR: begin
            if (i_ff == '0) begin
               dm_we = 1'b1;
               hm_we = 1'b1;
            end
            cm_we = (i_ff < ncount_ff);
            if (ip1 >= ncount_ff) begin
               i_in = '0;
               j_in = jp1;
            end else begin
               i_in = ip1;
            end
            state_in = S_RM_COL_RD;
         end

         // host vector
         S_EM_START: begin
            if (dcount_ff == DCW'(1)) begin
               okind_in = KIND_VEC_NONE;
               state_in = S_OUT1;
            end else begin
               j_in     = DCW'(1);
               state_in = S_EM_RD;
            end
         end
         S_EM_RD: state_in = S_EM_OUT;
         S_EM_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_VEC;
               rsp_addr_in  = PORT_AW'(dm_rdata_ff);
               rsp_cost_in  = hm_rdata_ff;
               rsp_last_in  = (8'(j_ff) == em_last_col);
               rsp_full_in  = full_ff;
               if (8'(j_ff) == em_last_col) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = jp1;
                  state_in = S_EM_RD;
               end
            end
         end

         // lookup: least cost row in the column
         S_LK_RD: begin
            if (i_ff >= ncount_ff) begin
               if (brv_ff) begin
                  state_in = S_LK_ADDR_RD;
               end else begin
                  okind_in = KIND_NO_ROUTE;
                  state_in = S_OUT1;
               end
            end else begin
               state_in = S_LK_CHK;
            end
         end
         S_LK_CHK: begin
            if (cm_rdata_ff < best_ff) begin
               best_in = cm_rdata_ff;
               br_in   = i_ff[RW-1:0];
               brv_in  = 1'b1;
            end
            i_in     = ip1;
            state_in = S_LK_RD;
         end
         S_LK_ADDR_RD: state_in = S_LK_ADDR_OUT;
         S_LK_ADDR_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_NEXT_HOP;
               rsp_addr_in  = PORT_AW'(dm_rdata_ff);
               rsp_cost_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_full_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end

         // single status response
         S_OUT1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = okind_ff;
               rsp_addr_in  = '0;
               rsp_cost_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // end of a column search
      if (col_hit) begin
         col_in = hit_col;
         if (func_ff == FUNC_LOOKUP) begin
            if (hit_col == '0) begin
               okind_in = KIND_NO_ROUTE;
               state_in = S_OUT1;
            end else begin
               i_in     = '0;
               best_in  = UNREACH;
               brv_in   = 1'b0;
               state_in = S_LK_RD;
            end
         end else if (att_ff) begin
            state_in = S_ATT_NEW;
         end else begin
            state_in = S_ADV_WR;
         end
      end
      if (col_miss) begin
         if (func_ff == FUNC_LOOKUP) begin
            okind_in = KIND_NO_ROUTE;
            state_in = S_OUT1;
         end else if (dcount_ff >= DCW'(DESTINATIONS)) begin
            if (att_ff) begin
               att_fail = 1'b1;
            end else begin
               dropped_in = 1'b1;
               state_in   = S_ADV_LAST;
            end
         end else begin
            col_in    = dcount_ff[CW-1:0];
            dcount_in = dcount_ff + DCW'(1);
            dm_we     = 1'b1;
            dm_waddr  = dcount_ff[CW-1:0];
            dm_wdata  = key_ff;
            hm_we     = 1'b1;
            hm_waddr  = dcount_ff[CW-1:0];
            hm_wdata  = UNREACH;
            i_in      = '0;
            state_in  = S_NCOL;
         end
      end

      // end of a row search
      if (row_hit) begin
         row_in = hit_row;
         if (func_ff == FUNC_REMOVE) begin
            open_in  = 1'b0;
            state_in = S_RM_START;
         end else begin
            col_in   = ncol_rd;
            j_in     = '0;
            state_in = S_ATT_FILL;
         end
      end
      if (row_miss) begin
         if (func_ff == FUNC_REMOVE) begin
            okind_in = KIND_NO_CHG;
            state_in = S_OUT1;
         end else if (ncount_ff >= NCW'(NEIGHBORS)) begin
            att_fail = 1'b1;
         end else begin
            j_in     = DCW'(1);
            state_in = S_FCOL_RD;
         end
      end

      // table overflow while attaching a neighbor
      if (att_fail) begin
         att_in = 1'b0;
         if (func_ff == FUNC_ADD) begin
            okind_in = KIND_NO_CHG;
            full_in  = 1'b1;
            state_in = S_OUT1;
         end else begin
            dropped_in = 1'b1;
            state_in   = S_ADV_ENTRY;
         end
      end
   end

   // column address memory
   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_waddr] <= dm_wdata;
      end
      dm_rdata_ff <= dmem[dm_raddr];
   end

   // host cost memory
   always_ff @(posedge clock) begin
      if (hm_we) begin
         hmem[hm_waddr] <= hm_wdata;
      end
      hm_rdata_ff <= hmem[hm_raddr];
   end

   // cost matrix memory
   always_ff @(posedge clock) begin
      if (cm_we) begin
         cmem[cm_waddr] <= cm_wdata;
      end
      cm_rdata_ff <= cmem[cm_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         host_ff      <= '0;
         dcount_ff    <= DCW'(1);
         ncount_ff    <= '0;
         cur_ff       <= '0;
         improved_ff  <= 1'b0;
         open_ff      <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         host_ff      <= host_in;
         dcount_ff    <= dcount_in;
         ncount_ff    <= ncount_in;
         cur_ff       <= cur_in;
         improved_ff  <= improved_in;
         open_ff      <= open_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      dst_ff      <= dst_in;
      cost_ff     <= cost_in;
      last_ff     <= last_in;
      present_ff  <= present_in;
      att_ff      <= att_in;
      ncol_ff     <= ncol_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      best_ff     <= best_in;
      br_ff       <= br_in;
      brv_ff      <= brv_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      full_ff     <= full_in;
      okind_ff    <= okind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_last_ff <= rsp_last_in;
      rsp_full_ff <= rsp_full_in;
   end

   // an accepted transaction always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a request");

   // table counts stay in range
   assert property (@(posedge clock) disable iff (reset)
      (ncount_ff <= NCW'(NEIGHBORS)) && (dcount_ff >= DCW'(1)) &&
      (dcount_ff <= DCW'(DESTINATIONS)))
      else $error("route table count out of range");

   // an open advertisement points at a live row between transactions
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && open_ff) |-> (NCW'(cur_ff) < ncount_ff))
      else $error("open advertisement on a dead row");

endmodule
